// File: rtl/nrle_pkg.sv
package nrle_pkg;

  // parser phase of the compressed stream
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_ESC       = 3'd1,
    PH_ONE       = 3'd2,
    PH_TWO_LO    = 3'd3,
    PH_TWO_HI    = 3'd4,
    PH_THREE_LO  = 3'd5,
    PH_THREE_MID = 3'd6,
    PH_THREE_HI  = 3'd7
  } phase_t;

  localparam logic [3:0]  CODE_ESC        = 4'd0;
  localparam logic [3:0]  CODE_LEN_ONE    = 4'd0;
  localparam logic [3:0]  CODE_LEN_TWO    = 4'd7;
  localparam logic [3:0]  CODE_LEN_THREE  = 4'd8;
  localparam logic [15:0] SHEET_BYTES_RST = 16'h6400;

  // one result transaction
  typedef struct packed {
    logic [7:0]  pixel_byte;
    logic [11:0] repeat_res;
    logic        last;
  } res_t;

  // results produced by one input item, handed to the result queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: rtl/nrle_decode.sv
module nrle_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data,
  input  logic          take,
  input  logic [3:0]    code_nibble,
  output nrle_pkg::push_t push
);
  import nrle_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  accum, accum_next;
  logic [3:0]  pend, pend_next;
  logic        half, half_next;
  logic [15:0] bytes_done, bytes_done_next;
  logic [15:0] sheet_bytes;

  logic [15:0] left;
  logic [16:0] left_full;
  logic [16:0] rem;
  logic        byte_last;
  logic        run_go;
  logic [11:0] run_len;
  logic [11:0] len_m;
  logic [10:0] pairs;
  logic        cut;
  logic        clr;
  res_t        rx;

  // bytes still to go in this sheet, zero means 65536
  assign left      = sheet_bytes - bytes_done;
  assign left_full = {(left == 16'd0), left};
  assign byte_last = (left_full == 17'd1);

  always_comb begin
    run_go  = 1'b0;
    run_len = '0;
    unique case (phase)
      PH_ESC: begin
        if (code_nibble != CODE_LEN_ONE && code_nibble != CODE_LEN_TWO &&
            code_nibble != CODE_LEN_THREE) begin
          run_go  = 1'b1;
          run_len = {8'd0, code_nibble};
        end
      end
      PH_ONE: begin
        run_go  = 1'b1;
        run_len = {8'd0, code_nibble};
      end
      PH_TWO_HI: begin
        run_go  = 1'b1;
        run_len = {4'd0, code_nibble, accum[3:0]};
      end
      PH_THREE_HI: begin
        run_go  = 1'b1;
        run_len = {code_nibble, accum};
      end
      default: begin
        run_go  = 1'b0;
        run_len = '0;
      end
    endcase
  end

  assign len_m = run_len - {11'd0, half};
  assign pairs = len_m[11:1];
  assign rem   = left_full - {16'd0, half};
  assign cut   = ({6'd0, pairs} >= rem);

  // next phase
  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        PH_IDLE:      phase_next = (code_nibble == CODE_ESC) ? PH_ESC : PH_IDLE;
        PH_ESC: begin
          if (code_nibble == CODE_LEN_ONE)        phase_next = PH_ONE;
          else if (code_nibble == CODE_LEN_TWO)   phase_next = PH_TWO_LO;
          else if (code_nibble == CODE_LEN_THREE) phase_next = PH_THREE_LO;
          else                                    phase_next = PH_IDLE;
        end
        PH_ONE:       phase_next = PH_IDLE;
        PH_TWO_LO:    phase_next = PH_TWO_HI;
        PH_TWO_HI:    phase_next = PH_IDLE;
        PH_THREE_LO:  phase_next = PH_THREE_MID;
        PH_THREE_MID: phase_next = PH_THREE_HI;
        PH_THREE_HI:  phase_next = PH_IDLE;
        default:      phase_next = PH_IDLE;
      endcase
    end
  end

  // results and datapath state
  always_comb begin
    push            = '0;
    accum_next      = accum;
    pend_next       = pend;
    half_next       = half;
    bytes_done_next = bytes_done;
    clr             = 1'b0;
    rx              = '0;
    if (take) begin
      unique case (phase)
        PH_IDLE: begin
          if (code_nibble != CODE_ESC) begin
            if (half) begin
              push.cnt = 2'd1;
              push.r0  = '{pixel_byte: {pend, code_nibble}, repeat_res: 12'd1,
                           last: byte_last};
              if (byte_last) begin
                clr = 1'b1;
              end else begin
                bytes_done_next = bytes_done + 16'd1;
                half_next       = 1'b0;
                pend_next       = '0;
              end
            end else begin
              pend_next = code_nibble;
              half_next = 1'b1;
            end
          end
        end
        PH_TWO_LO:    accum_next = {4'd0, code_nibble};
        PH_THREE_LO:  accum_next = {4'd0, code_nibble};
        PH_THREE_MID: accum_next = {code_nibble, accum[3:0]};
        default: begin
        end
      endcase

      if (run_go) begin
        accum_next = '0;
        if (run_len != 12'd0) begin
          // byte completed by the first zero pixel of the run
          if (half) begin
            push.cnt = 2'd1;
            push.r0  = '{pixel_byte: {pend, 4'd0}, repeat_res: 12'd1,
                         last: byte_last};
            if (byte_last) begin
              clr = 1'b1;
            end else begin
              bytes_done_next = bytes_done + 16'd1;
              half_next       = 1'b0;
              pend_next       = '0;
            end
          end
          // zero pairs as one repeated byte, cut at the sheet end
          if (!clr && pairs != 11'd0) begin
            if (cut) begin
              rx  = '{pixel_byte: 8'd0, repeat_res: rem[11:0], last: 1'b1};
              clr = 1'b1;
            end else begin
              rx = '{pixel_byte: 8'd0, repeat_res: {1'b0, pairs}, last: 1'b0};
              bytes_done_next = bytes_done_next + {5'd0, pairs};
            end
            if (half) begin
              push.cnt = 2'd2;
              push.r1  = rx;
            end else begin
              push.cnt = 2'd1;
              push.r0  = rx;
            end
          end
          if (!clr && len_m[0]) begin
            half_next = 1'b1;
            pend_next = '0;
          end
        end
      end

      if (clr) begin
        accum_next      = '0;
        pend_next       = '0;
        half_next       = 1'b0;
        bytes_done_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      accum       <= '0;
      pend        <= '0;
      half        <= 1'b0;
      bytes_done  <= '0;
      sheet_bytes <= SHEET_BYTES_RST;
    end else begin
      phase      <= phase_next;
      accum      <= accum_next;
      pend       <= pend_next;
      half       <= half_next;
      bytes_done <= bytes_done_next;
      if (cfg_we) begin
        sheet_bytes <= cfg_data;
      end
    end
  end

endmodule

// File: rtl/nrle_fifo.sv
module nrle_fifo (
  input  logic            clk,
  input  logic            rst,
  input  nrle_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output nrle_pkg::res_t  head
);
  import nrle_pkg::*;

  res_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign room      = (count <= 3'd2);
  assign head      = mem[rd_ptr];

  assign count_next = count + {1'b0, push.cnt} - {2'd0, pop};

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.cnt;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

endmodule

// File: rtl/nibble_rle_pixel_decoder.sv
// a code's results are registered in the four-entry result queue before they are offered
// throughput: one code per cycle; a code may yield two results, drained one per cycle
// while out_ready is high; in_ready drops while fewer than two queue slots are free
// reset: synchronous active-high rst clears parser state, byte counter and queue,
// and loads sheet_bytes with 25600
module nibble_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  code_nibble,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_byte,
  output logic [11:0] repeat_res,
  output logic        last
);
  import nrle_pkg::*;

  push_t push;
  res_t  head;
  logic  room;
  logic  take;

  // a code transaction completes when the queue can absorb two results
  assign in_ready = room;
  assign take     = in_valid && in_ready;

  // parser, pixel packing and sheet counting
  nrle_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .take        (take),
    .code_nibble (code_nibble),
    .push        (push)
  );

  // result queue decouples the output side from the parser
  nrle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // output payload straight from the queue head register
  assign pixel_byte = head.pixel_byte;
  assign repeat_res = head.repeat_res;
  assign last       = head.last;

endmodule

// File: rtl/nrle_checker.sv
module nrle_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  pixel_byte,
  input logic [11:0] repeat_res,
  input logic        last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_byte) &&
    $stable(repeat_res) && $stable(last))
    else $error("result changed while stalled");

  // every result writes at least one byte
  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> repeat_res != 12'd0)
    else $error("zero repeat count");

  // only zero runs repeat
  a_rep_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && repeat_res != 12'd1 |-> pixel_byte == 8'd0)
    else $error("repeated nonzero byte");

  // reset empties the queue and opens the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not cleared by reset");

endmodule

bind nibble_rle_pixel_decoder nrle_checker u_nrle_checker (.*);

// File: dv/tb_top.sv
import nrle_pkg::*;

// expected-result store and decoder state tracking
class rle_scoreboard;
  logic [15:0] sheet_bytes;
  phase_t      phase;
  logic [11:0] len_acc;
  logic [3:0]  pend_hi;
  bit          half;
  logic [15:0] done_cnt;
  res_t        exp_q[$];
  int          errors;

  function new();
    sheet_bytes = SHEET_BYTES_RST;
    errors = 0;
    clear_sheet();
  endfunction

  function void clear_sheet();
    phase = PH_IDLE;
    len_acc = '0;
    pend_hi = '0;
    half = 1'b0;
    done_cnt = '0;
  endfunction

  // bytes left in the sheet, a zero difference means a full 65536
  function int unsigned room();
    logic [15:0] r;
    r = sheet_bytes - done_cnt;
    return (r == 16'd0) ? 65536 : int'(r);
  endfunction

  function void push_res(logic [7:0] b, logic [11:0] rep, logic lst);
    res_t r;
    r.pixel_byte = b;
    r.repeat_res = rep;
    r.last = lst;
    exp_q.push_back(r);
  endfunction

  // completes the pending byte, returns 1 when the sheet closed
  function bit emit_byte(logic [3:0] lo);
    logic [7:0] b;
    b = {pend_hi, lo};
    if (room() == 1) begin
      push_res(b, 12'd1, 1'b1);
      clear_sheet();
      return 1'b1;
    end
    push_res(b, 12'd1, 1'b0);
    done_cnt = done_cnt + 16'd1;
    half = 1'b0;
    pend_hi = '0;
    return 1'b0;
  endfunction

  function void run_zeros(logic [11:0] len_in);
    int unsigned len, pairs, rem;
    len = len_in;
    phase = PH_IDLE;
    len_acc = '0;
    if (len == 0) return;
    if (half) begin
      if (emit_byte(4'd0)) return;
      len--;
    end
    pairs = len >> 1;
    if (pairs > 0) begin
      rem = room();
      if (pairs >= rem) begin
        push_res(8'h00, 12'(rem), 1'b1);
        clear_sheet();
        return;
      end
      push_res(8'h00, 12'(pairs), 1'b0);
      done_cnt = done_cnt + 16'(pairs);
    end
    if (len[0]) begin
      half = 1'b1;
      pend_hi = '0;
    end
  endfunction

  function void note_code(logic [3:0] n);
    case (phase)
      PH_IDLE: begin
        if (n == CODE_ESC) phase = PH_ESC;
        else if (half) void'(emit_byte(n));
        else begin
          pend_hi = n;
          half = 1'b1;
        end
      end
      PH_ESC: begin
        if (n == CODE_LEN_ONE) phase = PH_ONE;
        else if (n == CODE_LEN_TWO) phase = PH_TWO_LO;
        else if (n == CODE_LEN_THREE) phase = PH_THREE_LO;
        else run_zeros(12'(n));
      end
      PH_ONE: run_zeros(12'(n));
      PH_TWO_LO: begin
        len_acc = 12'(n);
        phase = PH_TWO_HI;
      end
      PH_TWO_HI: run_zeros(len_acc | (12'(n) << 4));
      PH_THREE_LO: begin
        len_acc = 12'(n);
        phase = PH_THREE_MID;
      end
      PH_THREE_MID: begin
        len_acc = len_acc | (12'(n) << 4);
        phase = PH_THREE_HI;
      end
      default: run_zeros(len_acc | (12'(n) << 8));
    endcase
  endfunction

  function void check_result(logic [7:0] b, logic [11:0] rep, logic lst);
    res_t want;
    if (exp_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got byte %h repeat %0d last %0b",
               $time, b, rep, lst);
      return;
    end
    want = exp_q.pop_front();
    if (b !== want.pixel_byte) begin
      errors++;
      $display("%0t: pixel_byte expected %h got %h", $time, want.pixel_byte, b);
    end
    if (rep !== want.repeat_res) begin
      errors++;
      $display("%0t: repeat_res expected %0d got %0d", $time, want.repeat_res, rep);
    end
    if (lst !== want.last) begin
      errors++;
      $display("%0t: last expected %0b got %0b", $time, want.last, lst);
    end
  endfunction

  function int pending();
    return exp_q.size();
  endfunction
endclass

module tb_top;
  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  code_nibble = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  pixel_byte;
  logic [11:0] repeat_res;
  logic        last;

  rle_scoreboard sb = new();

  // idle burst chance in percent, per side, changed per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int codes_sent = 0;

  // directed opening stream: literal extremes, every escape form, odd runs,
  // zero-length runs and the longest run
  logic [3:0] opening_codes[] = '{
    4'd15, 4'd1,                       // two literals, all-ones and lowest
    4'd9, 4'd0, 4'd3,                  // short escape completes the held pixel
    4'd0, 4'd0, 4'd0,                  // one-nibble length of zero, no result
    4'd0, 4'd1,                        // odd run leaves a zero pixel pending
    4'd6,                              // literal completes the pending zero
    4'd0, 4'd7, 4'd15, 4'd15,          // two-nibble length 255
    4'd0, 4'd8, 4'd15, 4'd15, 4'd15,   // three-nibble length 4095
    4'd0, 4'd8, 4'd0, 4'd0, 4'd0,      // three-nibble zero length
    4'd0, 4'd15                        // largest short escape
  };

  nibble_rle_pixel_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_nibble(code_nibble),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_byte (pixel_byte),
    .repeat_res (repeat_res),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAIL nibble_rle_pixel_decoder");
    $finish;
  end

  // result side: check each transaction, stall in random bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(pixel_byte, repeat_res, last);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one code transaction, with an optional idle burst ahead of it
  task automatic send_code(input logic [3:0] n);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    code_nibble <= n;
    do @(posedge clk); while (!in_ready);
    sb.note_code(n);
    codes_sent++;
  endtask

  // one well-formed symbol with random content, or a stray nibble
  task automatic send_symbol(input bit long_runs);
    int pick;
    logic [3:0] sel;
    pick = $urandom_range(0, 99);
    if (long_runs && pick < 80) begin
      // near-maximum runs to reach the big sheet sizes quickly
      send_code(CODE_ESC);
      send_code(CODE_LEN_THREE);
      send_code(4'($urandom_range(0, 15)));
      send_code(4'($urandom_range(0, 15)));
      send_code(4'hf);
    end else if (pick < 35) begin
      send_code(4'($urandom_range(1, 15)));
    end else if (pick < 50) begin
      do sel = 4'($urandom_range(1, 15));
      while (sel == CODE_LEN_TWO || sel == CODE_LEN_THREE);
      send_code(CODE_ESC);
      send_code(sel);
    end else if (pick < 60) begin
      send_code(CODE_ESC);
      send_code(CODE_LEN_ONE);
      send_code(4'($urandom_range(0, 15)));
    end else if (pick < 75) begin
      send_code(CODE_ESC);
      send_code(CODE_LEN_TWO);
      send_code(4'($urandom_range(0, 15)));
      send_code(4'($urandom_range(0, 15)));
    end else if (pick < 90) begin
      send_code(CODE_ESC);
      send_code(CODE_LEN_THREE);
      send_code(4'($urandom_range(0, 15)));
      send_code(4'($urandom_range(0, 15)));
      send_code(4'($urandom_range(0, 15)));
    end else begin
      send_code(4'($urandom_range(0, 15)));
    end
  endtask

  task automatic send_symbols(input int count, input bit long_runs);
    int stop_at;
    stop_at = codes_sent + count;
    while (codes_sent < stop_at) send_symbol(long_runs);
  endtask

  // the block is idle once every result is back and the pipeline has settled
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_sheet_size(input logic [15:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= v;
    sb.sheet_bytes = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_idling();
    tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
  endtask

  initial begin
    logic [15:0] lowered;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed stream at the reset sheet size
    pick_idling();
    foreach (opening_codes[i]) send_code(opening_codes[i]);

    // every byte closes the sheet
    set_sheet_size(16'd1);
    pick_idling();
    send_symbols(50, 1'b0);

    // tiny sheets, frequent truncation of runs and pending pixels
    set_sheet_size(16'($urandom_range(2, 6)));
    pick_idling();
    send_symbols(80, 1'b0);

    // largest explicit size, then zero meaning 65536
    set_sheet_size(16'hffff);
    pick_idling();
    send_symbols(250, 1'b1);
    set_sheet_size(16'h0000);
    pick_idling();
    send_symbols(250, 1'b1);

    // size lowered below the bytes already written, counter has to wrap
    set_sheet_size(16'hffff);
    pick_idling();
    send_symbols(30, 1'b1);
    drain_results();
    lowered = (sb.done_cnt > 16'd1) ? (sb.done_cnt >> 1) : 16'd1;
    set_sheet_size(lowered);
    send_symbols(180, 1'b1);

    // assorted moderate sizes
    repeat (3) begin
      set_sheet_size(16'($urandom_range(1, 300)));
      pick_idling();
      send_symbols(50, 1'b0);
    end

    // closing stretch at full rate on both sides
    set_sheet_size(16'($urandom_range(1, 65535)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_symbols(60, 1'b0);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS nibble_rle_pixel_decoder");
    end else begin
      $display("FAIL nibble_rle_pixel_decoder");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/nrle_pkg.sv
rtl/nrle_decode.sv
rtl/nrle_fifo.sv
rtl/nibble_rle_pixel_decoder.sv
rtl/nrle_checker.sv
dv/tb_top.sv
